### rtl/core/mp2a_pkg.sv
// ----------------------------------------------------------------------------
// mp2a_pkg
// Shared types and constants of the 2-D max pooling unit with argmax.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mp2a_pkg;

  localparam int POOL_W    = 4;     // pool edge register width
  localparam int DIM_W     = 11;    // plane width / height register width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  localparam int OCNT_W    = 10;    // output column / row counters
  localparam int WIN_W     = 3;     // position inside the window
  localparam int POS_W     = 6;     // window-local argmax index
  localparam int ROW_LIMIT = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_EDGE    = 2'd0,
    REG_PLANE_WIDTH  = 2'd1,
    REG_PLANE_HEIGHT = 2'd2
  } cfg_reg_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } cfg_t;

  // per-sample window bookkeeping handed from the scan stage
  typedef struct packed {
    logic              active;      // sample lies in a kept window
    logic              first;       // first sample of its window
    logic              last;        // bottom right corner of its window
    logic              plane_done;  // last window of the plane
    logic [OCNT_W-1:0] column;      // output column, memory address
    logic [POS_W-1:0]  pos;         // kh*pool+kw
  } scan_info_t;

endpackage : mp2a_pkg

`default_nettype wire

### rtl/core/max_pool_2d_with_argmax_unit.sv
// ----------------------------------------------------------------------------
// max_pool_2d_with_argmax_unit
// Streaming non-overlapping 2-D max pooling with window-local argmax.
// ----------------------------------------------------------------------------
// Takes one sample per clock in raster order and gives one result for each
// completed pool_edge x pool_edge window. The running maximum and its index
// for each output column live in a column memory with a registered read:
// a sample reads its column when accepted and writes the update back as it
// leaves the update stage, with a bypass for back-to-back samples of the same
// column. A window's result goes from the update stage into the output register.
// Throughput is one sample per clock; in_stall rises only while a result in
// the update stage waits on a result held with out_stall high. Configuration
// registers are to be written while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_2d_with_argmax_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_POOL    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [mp2a_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mp2a_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_max_value,
  output logic [mp2a_pkg::POS_W-1:0]           out_max_position,
  output logic                                 out_plane_done
);

  import mp2a_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int ENTRY_W = SAMPLE_BITS + POS_W;

  // configuration registers
  logic [POOL_W-1:0] pool_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  cfg_t              cfg_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r   <= POOL_W'(2);
      width_r  <= DIM_W'(32);
      height_r <= DIM_W'(32);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_POOL_EDGE:    pool_r   <= cfg_data[POOL_W-1:0];
        REG_PLANE_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_PLANE_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pool_r == '0) begin
      cfg_eff.pool = POOL_W'(1);
    end else if (32'(pool_r) > MAX_POOL) begin
      cfg_eff.pool = POOL_W'(MAX_POOL);
    end else begin
      cfg_eff.pool = pool_r;
    end
    if (width_r == '0) begin
      cfg_eff.width = DIM_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      cfg_eff.width = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_eff.width = width_r;
    end
    if (height_r == '0) begin
      cfg_eff.height = DIM_W'(1);
    end else if (32'(height_r) > ROW_LIMIT) begin
      cfg_eff.height = DIM_W'(ROW_LIMIT);
    end else begin
      cfg_eff.height = height_r;
    end
  end

  // scan stage
  scan_info_t scan_info;
  logic       accept;

  mp2a_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .cfg     (cfg_eff),
    .info    (scan_info)
  );

  // update stage
  logic                          s1_valid_r;
  scan_info_t                    s1_info_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          byp_valid_r;
  logic [ENTRY_W-1:0]            byp_data_r;
  logic [ENTRY_W-1:0]            rd_data;
  logic [ENTRY_W-1:0]            old_entry;
  logic signed [SAMPLE_BITS-1:0] old_best;
  logic signed [SAMPLE_BITS-1:0] new_best;
  logic [POS_W-1:0]              new_pos;
  logic [ENTRY_W-1:0]            wr_data;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          wr_en;
  logic                          produce;
  logic                          out_free;
  logic                          s1_adv;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic [POS_W-1:0]              out_pos_r;
  logic                          out_done_r;

  always_comb begin
    old_entry = byp_valid_r ? byp_data_r : rd_data;
    old_best  = old_entry[ENTRY_W-1:POS_W];
    // first sample of a window always replaces; ties keep the held one
    if (s1_info_r.first || (s1_sample_r > old_best)) begin
      new_best = s1_sample_r;
      new_pos  = s1_info_r.pos;
    end else begin
      new_best = old_best;
      new_pos  = old_entry[POS_W-1:0];
    end
    wr_data  = {new_best, new_pos};
    wr_addr  = ADDR_W'(s1_info_r.column);
    rd_addr  = ADDR_W'(scan_info.column);
    produce  = s1_valid_r && s1_info_r.active && s1_info_r.last;
    out_free = !out_valid_r || !out_stall;
    s1_adv   = !produce || out_free;
    wr_en    = s1_valid_r && s1_info_r.active && s1_adv;
    in_stall = s1_valid_r && !s1_adv;
    accept   = in_valid && !in_stall;
  end

  mp2a_ram #(
    .DEPTH  (MAX_WIDTH),
    .WIDTH  (ENTRY_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // payload of the update stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r   <= scan_info;
      s1_sample_r <= in_sample;
      byp_data_r  <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r  <= 1'b1;
        // memory read misses the write landing on the same edge
        byp_valid_r <= wr_en && (wr_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && out_free) begin
      out_value_r <= new_best;
      out_pos_r   <= new_pos;
      out_done_r  <= s1_info_r.plane_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_max_value    = out_value_r;
  assign out_max_position = out_pos_r;
  assign out_plane_done   = out_done_r;

endmodule : max_pool_2d_with_argmax_unit

`default_nettype wire

### rtl/core/mp2a_ram.sv
// ----------------------------------------------------------------------------
// mp2a_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp2a_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 22,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : mp2a_ram

`default_nettype wire

### rtl/core/mp2a_scan.sv
// ----------------------------------------------------------------------------
// mp2a_scan
// Raster position counters; classifies each sample against its window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp2a_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  mp2a_pkg::cfg_t      cfg,
  output mp2a_pkg::scan_info_t info
);

  import mp2a_pkg::*;

  logic [DIM_W-1:0]  in_col_r, in_col_nxt;
  logic [OCNT_W-1:0] in_row_r, in_row_nxt;
  logic [WIN_W-1:0]  win_col_r, win_col_nxt;
  logic [WIN_W-1:0]  win_row_r, win_row_nxt;
  logic [OCNT_W-1:0] out_col_r, out_col_nxt;
  logic [OCNT_W-1:0] out_row_r, out_row_nxt;

  logic [14:0] col_p1, col_p2, row_p1, row_p2;
  logic        col_ok, col_end, row_ok, row_end;
  logic [6:0]  pos_full;
  logic [POOL_W-1:0] pool_m1;

  // window membership without dividing: c < w/p  <=>  (c+1)*p <= w
  always_comb begin
    col_p1  = (15'(out_col_r) + 15'd1) * 15'(cfg.pool);
    col_p2  = (15'(out_col_r) + 15'd2) * 15'(cfg.pool);
    row_p1  = (15'(out_row_r) + 15'd1) * 15'(cfg.pool);
    row_p2  = (15'(out_row_r) + 15'd2) * 15'(cfg.pool);
    col_ok  = col_p1 <= 15'(cfg.width);
    col_end = col_p2 > 15'(cfg.width);
    row_ok  = row_p1 <= 15'(cfg.height);
    row_end = row_p2 > 15'(cfg.height);
    pool_m1 = cfg.pool - POOL_W'(1);
    pos_full = 7'(win_row_r) * 7'(cfg.pool) + 7'(win_col_r);

    info.active     = col_ok && row_ok &&
                      (POOL_W'(win_col_r) < cfg.pool) &&
                      (POOL_W'(win_row_r) < cfg.pool);
    info.pos        = pos_full[POS_W-1:0];
    info.first      = (pos_full[POS_W-1:0] == '0);
    info.last       = (POOL_W'(win_row_r) == pool_m1) && (POOL_W'(win_col_r) == pool_m1);
    info.plane_done = col_end && row_end;
    info.column     = out_col_r;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    win_col_nxt = win_col_r;
    win_row_nxt = win_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (advance) begin
      if ((12'(in_col_r) + 12'd1) >= 12'(cfg.width)) begin
        in_col_nxt  = '0;
        win_col_nxt = '0;
        out_col_nxt = '0;
        if ((12'(in_row_r) + 12'd1) >= 12'(cfg.height)) begin
          in_row_nxt  = '0;
          win_row_nxt = '0;
          out_row_nxt = '0;
        end else begin
          in_row_nxt = in_row_r + OCNT_W'(1);
          if ((POOL_W'(win_row_r) + POOL_W'(1)) >= cfg.pool) begin
            win_row_nxt = '0;
            out_row_nxt = out_row_r + OCNT_W'(1);
          end else begin
            win_row_nxt = win_row_r + WIN_W'(1);
          end
        end
      end else begin
        in_col_nxt = in_col_r + DIM_W'(1);
        if ((POOL_W'(win_col_r) + POOL_W'(1)) >= cfg.pool) begin
          win_col_nxt = '0;
          out_col_nxt = out_col_r + OCNT_W'(1);
        end else begin
          win_col_nxt = win_col_r + WIN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      win_col_r <= '0;
      win_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      win_col_r <= win_col_nxt;
      win_row_r <= win_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule : mp2a_scan

`default_nettype wire

### rtl/core/mp2a_checker.sv
// ----------------------------------------------------------------------------
// mp2a_checker
// Port-level checks of the max pooling unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp2a_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_max_value,
  input logic [5:0]             out_max_position,
  input logic                   out_plane_done
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // input backpressure comes only from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  // a new result traces back to an accepted transaction through the update stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_max_value) &&
      $stable(out_max_position) && $stable(out_plane_done)))
    else $error("stalled result changed");

endmodule : mp2a_checker

bind max_pool_2d_with_argmax_unit mp2a_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mp2a_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_max_value    (out_max_value),
  .out_max_position (out_max_position),
  .out_plane_done   (out_plane_done)
);

`default_nettype wire
